// File: hdl/i2cmws_pkg.sv
// Shared types and constants for the I2C master write sequencer.
`default_nettype none
package i2cmws_pkg;

  // Command codes carried in the command field of a request item.
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ADDRESS = 2'd1,
    CMD_DATA    = 2'd2,
    CMD_STOP    = 2'd3
  } cmd_e_t;

  // One request item as it arrives on the push side.
  typedef struct packed {
    logic [1:0] command;
    logic [6:0] address;
    logic       rw;
    logic [7:0] data_byte;
  } request_t;

  // One pin step as it leaves on the pop side.
  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_released;
    logic [15:0] hold_ticks;
    logic        last;
  } result_t;

  // Classified command held in the queue between front and back.
  typedef struct packed {
    cmd_e_t     kind;
    logic [7:0] bits;
  } job_t;

  // Handshake between the queue and the sequencer.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_port_t;

  // Sequencer states, one per kind of pin step.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_SDA,
    ST_START_SCL,
    ST_BIT_HIGH,
    ST_BIT_LOW,
    ST_ACK_RELEASE,
    ST_ACK_HIGH,
    ST_ACK_LOW,
    ST_ACK_END,
    ST_STOP_SDA,
    ST_STOP_SCL,
    ST_STOP_RISE
  } seq_state_t;

  // Register indexes and reset values.
  localparam logic        REG_HALF_PERIOD   = 1'b0;
  localparam logic        REG_SETUP         = 1'b1;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd30;
  localparam logic [15:0] SETUP_RESET       = 16'd15;
  localparam logic [2:0]  FIRST_BIT_COUNT   = 3'd7;

endpackage
`default_nettype wire

// File: hdl/i2cmws_front.sv
// Front end: classifies an incoming command into a queue job.
`default_nettype none
module i2cmws_front (
  input  wire i2cmws_pkg::request_t request,
  output i2cmws_pkg::job_t         job
);
  import i2cmws_pkg::*;

  // Address and rw form one byte sent MSB first; data sends its byte as is.
  always_comb begin
    job.kind = cmd_e_t'(request.command);
    case (cmd_e_t'(request.command))
      CMD_ADDRESS: job.bits = {request.address, request.rw};
      CMD_DATA:    job.bits = request.data_byte;
      default:     job.bits = request.data_byte;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/i2cmws_queue.sv
// Short job queue between the front end and the sequencer.
`default_nettype none
module i2cmws_queue #(
  parameter int DEPTH = 2
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          wr_en,
  input  wire i2cmws_pkg::job_t        wr_job,
  output logic                         full,
  input  wire                          rd_en,
  output i2cmws_pkg::job_port_t        rd_port
);
  import i2cmws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Status and read port.
  assign full          = (count == CNT_W'(DEPTH));
  assign rd_port.valid = (count != '0);
  assign rd_port.job   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count, wrapping at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cmws_back.sv
// Back end: steps through the pin sequence of one job and holds each result.
`default_nettype none
module i2cmws_back (
  input  wire                         clk,
  input  wire                         rst,
  input  wire i2cmws_pkg::job_port_t  job_port,
  output logic                        job_take,
  input  wire [15:0]                  half_ticks,
  input  wire [15:0]                  setup_ticks,
  output i2cmws_pkg::result_t         result,
  output logic                        empty,
  input  wire                         pop
);
  import i2cmws_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  logic       scl_now;
  logic       scl_next;
  logic       sda_now;
  logic       sda_next;
  logic [7:0] shift;
  logic [7:0] shift_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       is_addr;
  logic       is_addr_next;
  logic       out_valid;
  result_t    out_item;
  result_t    step;
  logic       emit;
  logic       advance;

  // The result register frees up when empty or being popped.
  assign advance = !out_valid || pop;
  assign empty   = !out_valid;
  assign result  = out_item;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_port.valid) begin
          case (job_port.job.kind)
            CMD_START:   state_next = ST_START_SDA;
            CMD_ADDRESS: state_next = ST_BIT_HIGH;
            CMD_DATA:    state_next = ST_BIT_HIGH;
            CMD_STOP:    state_next = ST_STOP_SDA;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_START_SDA:   if (advance) state_next = ST_START_SCL;
      ST_START_SCL:   if (advance) state_next = ST_IDLE;
      ST_BIT_HIGH:    if (advance) state_next = ST_BIT_LOW;
      ST_BIT_LOW: begin
        if (advance) begin
          state_next = (cnt == '0) ? ST_ACK_RELEASE : ST_BIT_HIGH;
        end
      end
      ST_ACK_RELEASE: if (advance) state_next = ST_ACK_HIGH;
      ST_ACK_HIGH:    if (advance) state_next = ST_ACK_LOW;
      ST_ACK_LOW:     if (advance) state_next = ST_ACK_END;
      ST_ACK_END:     if (advance) state_next = ST_IDLE;
      ST_STOP_SDA:    if (advance) state_next = ST_STOP_SCL;
      ST_STOP_SCL:    if (advance) state_next = ST_STOP_RISE;
      ST_STOP_RISE:   if (advance) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // Step contents and line updates for the current state.
  always_comb begin
    scl_next          = scl_now;
    sda_next          = sda_now;
    shift_next        = shift;
    cnt_next          = cnt;
    is_addr_next      = is_addr;
    job_take          = 1'b0;
    emit              = 1'b0;
    step.scl_level    = scl_now;
    step.sda_level    = sda_now;
    step.sda_released = 1'b0;
    step.hold_ticks   = half_ticks;
    step.last         = 1'b0;
    case (state)
      ST_IDLE: begin
        job_take     = job_port.valid;
        shift_next   = job_port.job.bits;
        cnt_next     = FIRST_BIT_COUNT;
        is_addr_next = (job_port.job.kind == CMD_ADDRESS);
      end
      ST_START_SDA: begin
        emit           = advance;
        sda_next       = 1'b0;
        step.sda_level = 1'b0;
      end
      ST_START_SCL: begin
        emit            = advance;
        scl_next        = 1'b0;
        step.scl_level  = 1'b0;
        step.hold_ticks = setup_ticks;
        step.last       = 1'b1;
      end
      ST_BIT_HIGH: begin
        emit           = advance;
        scl_next       = 1'b1;
        sda_next       = shift[7];
        step.scl_level = 1'b1;
        step.sda_level = shift[7];
      end
      ST_BIT_LOW: begin
        // The rw bit's low phase holds for no time before the acknowledge.
        emit           = advance;
        scl_next       = 1'b0;
        step.scl_level = 1'b0;
        if (is_addr && cnt == '0) begin
          step.hold_ticks = '0;
        end
        if (advance) begin
          shift_next = {shift[6:0], 1'b0};
          cnt_next   = cnt - 1'b1;
        end
      end
      ST_ACK_RELEASE: begin
        emit              = advance;
        step.sda_released = 1'b1;
      end
      ST_ACK_HIGH: begin
        emit              = advance;
        scl_next          = 1'b1;
        step.scl_level    = 1'b1;
        step.sda_released = 1'b1;
      end
      ST_ACK_LOW: begin
        emit              = advance;
        scl_next          = 1'b0;
        step.scl_level    = 1'b0;
        step.sda_released = 1'b1;
      end
      ST_ACK_END: begin
        emit            = advance;
        step.hold_ticks = '0;
        step.last       = 1'b1;
      end
      ST_STOP_SDA: begin
        emit           = advance;
        sda_next       = 1'b0;
        step.sda_level = 1'b0;
      end
      ST_STOP_SCL: begin
        emit           = advance;
        scl_next       = 1'b1;
        step.scl_level = 1'b1;
      end
      ST_STOP_RISE: begin
        emit            = advance;
        sda_next        = 1'b1;
        step.sda_level  = 1'b1;
        step.hold_ticks = setup_ticks;
        step.last       = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state: sequencer, line levels and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scl_now   <= 1'b1;
      sda_now   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      scl_now <= (emit) ? scl_next : scl_now;
      sda_now <= (emit) ? sda_next : sda_now;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the held result.
  always_ff @(posedge clk) begin
    shift   <= shift_next;
    cnt     <= cnt_next;
    is_addr <= is_addr_next;
    if (emit) begin
      out_item <= step;
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2c_master_write_sequencer.sv
// Top level of the I2C master write sequencer with its register port.
//
//   Channel   Handshake           Payload
//   request   push / full         request (command, address, rw, data_byte)
//   result    pop / empty         result (scl_level, sda_level, sda_released,
//                                         hold_ticks, last)
//   config    psel/penable/pwrite half_period_ticks at 0x0, setup_ticks at 0x4
//
// The sequencer loads a job from the queue in its idle state and then emits
// one pin step per cycle while the result register is free or being popped.
// Steps are held in a single result register, so a stalled pop stops the
// sequencer while the queue keeps accepting items until it fills.
// Reset is synchronous; it empties the queue and sets both lines high.
`default_nettype none
module i2c_master_write_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  output logic                        full,
  input  wire i2cmws_pkg::request_t   request,
  input  wire                         pop,
  output logic                        empty,
  output i2cmws_pkg::result_t         result,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [2:0]                   paddr,
  input  wire [31:0]                  pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import i2cmws_pkg::*;

  logic        [15:0] half_period_ticks;
  logic        [15:0] setup_ticks;
  logic               cfg_write;
  logic               push_ok;
  logic               job_take;
  job_t               new_job;
  job_port_t          job_port;

  // Register port: always ready, decoded on the word address bit.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_SETUP) ? {16'd0, setup_ticks}
                                             : {16'd0, half_period_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      setup_ticks       <= SETUP_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HALF_PERIOD) begin
        half_period_ticks <= pwdata[15:0];
      end else begin
        setup_ticks <= pwdata[15:0];
      end
    end
  end

  // Accepted items are classified and queued.
  assign push_ok = push && !full;

  i2cmws_front u_front (
    .request (request),
    .job     (new_job)
  );

  i2cmws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push_ok),
    .wr_job  (new_job),
    .full    (full),
    .rd_en   (job_take),
    .rd_port (job_port)
  );

  // Pin step sequencer.
  i2cmws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_port    (job_port),
    .job_take    (job_take),
    .half_ticks  (half_period_ticks),
    .setup_ticks (setup_ticks),
    .result      (result),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
`default_nettype wire
